[hdl/lgs_pkg.sv]
`default_nettype none

package lgs_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	// wide enough for any grid size and the register values
	localparam int DIM_W = 11;
	localparam int CFG_W = 7;
	localparam int IDX_W = 6;
	localparam int OP_W  = 2;

	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ    = 2'd1;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
	localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

	typedef struct packed {
		logic cap_item;
		logic clr_step;
		logic acc_rd;
		logic acc_wr;
		logic adv_init;
		logic adv_prime;
		logic adv_next;
		logic adv_fetch;
		logic adv_sweep;
		logic adv_write;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_write;
		logic is_read;
		logic is_advance;
		logic oor;
		logic empty;
		logic row_last;
		logic col_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

[hdl/lgs_ctrl.sv]
`default_nettype none

module lgs_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           s_tvalid,
	output logic          s_tready,
	input  lgs_pkg::sts_t sts,
	output lgs_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		CLEAR,
		IDLE,
		DISPATCH,
		ACC_RD,
		ACC_DATA,
		ADV_INIT,
		ADV_PRIME,
		ADV_NEXT,
		ADV_FETCH,
		ADV_SWEEP,
		ADV_WRITE,
		RESP
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
		end else begin
			unique case (state_q)
				CLEAR: begin
					if (sts.clr_last) state_q <= IDLE;
				end
				IDLE: begin
					if (s_tvalid) state_q <= DISPATCH;
				end
				DISPATCH: begin
					if (sts.is_write || sts.is_read) begin
						state_q <= sts.oor ? RESP : ACC_RD;
					end else if (sts.is_advance) begin
						state_q <= sts.empty ? RESP : ADV_INIT;
					end else begin
						state_q <= RESP;
					end
				end
				ACC_RD:    state_q <= ACC_DATA;
				ACC_DATA:  state_q <= RESP;
				ADV_INIT:  state_q <= ADV_PRIME;
				ADV_PRIME: state_q <= ADV_NEXT;
				ADV_NEXT:  state_q <= ADV_FETCH;
				ADV_FETCH: state_q <= ADV_SWEEP;
				ADV_SWEEP: begin
					if (sts.col_last) state_q <= ADV_WRITE;
				end
				ADV_WRITE: begin
					state_q <= sts.row_last ? RESP : ADV_NEXT;
				end
				RESP: begin
					if (sts.out_free) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		s_tready      = (state_q == IDLE);
		cmd.cap_item  = (state_q == IDLE) && s_tvalid;
		cmd.clr_step  = (state_q == CLEAR);
		cmd.acc_rd    = (state_q == ACC_RD);
		cmd.acc_wr    = (state_q == ACC_DATA) && sts.is_write;
		cmd.adv_init  = (state_q == ADV_INIT);
		cmd.adv_prime = (state_q == ADV_PRIME);
		cmd.adv_next  = (state_q == ADV_NEXT);
		cmd.adv_fetch = (state_q == ADV_FETCH);
		cmd.adv_sweep = (state_q == ADV_SWEEP);
		cmd.adv_write = (state_q == ADV_WRITE);
		cmd.res_load  = (state_q == RESP) && sts.out_free;
	end

endmodule

`default_nettype wire

[hdl/lgs_dp.sv]
`default_nettype none

module lgs_dp #(
	parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = lgs_pkg::DEF_MAX_COLS
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire                             cfg_index,
	input  wire  [lgs_pkg::CFG_W-1:0]       cfg_data,
	input  wire  [15:0]                     s_tdata,
	output logic                            m_tvalid,
	input  wire                             m_tready,
	output logic [7:0]                      m_tdata,
	input  lgs_pkg::cmd_t                   cmd,
	output lgs_pkg::sts_t                   sts
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int DW = lgs_pkg::DIM_W;

	logic [lgs_pkg::CFG_W-1:0] rows_q, cols_q;
	logic [DW-1:0]             nr, nc, rows_ext, cols_ext;

	logic [lgs_pkg::OP_W-1:0]  op_q;
	logic [lgs_pkg::IDX_W-1:0] item_row_q, item_col_q;
	logic                      item_cin_q;

	logic [MAX_COLS-1:0] mem [MAX_ROWS];
	logic [MAX_COLS-1:0] rdata_q, top_q, mid_q, bot_q, new_row_q, mod_row, wdata;
	logic [RW-1:0]       raddr, waddr, item_addr, rc_q;
	logic [RW:0]         rc_nxt;
	logic [CW-1:0]       cc_q, col_sel;
	logic [CW:0]         cc_nxt;
	logic                re, we;
	logic [DW-1:0]       row_ext, col_ext;
	logic                oor_w, row_more, col_in, right_in, new_bit;
	logic [2:0]          lft_q;
	logic [3:0]          count;
	logic                out_valid_q, out_cell_q, out_oor_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= lgs_pkg::ROWS_RESET;
			cols_q <= lgs_pkg::COLS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lgs_pkg::REG_ROWS: rows_q <= cfg_data;
				lgs_pkg::REG_COLS: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rows_ext = DW'(rows_q);
	assign cols_ext = DW'(cols_q);
	assign nr = (rows_ext > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : rows_ext;
	assign nc = (cols_ext > DW'(MAX_COLS)) ? DW'(MAX_COLS) : cols_ext;

	// captured item
	always_ff @(posedge clk) begin
		if (cmd.cap_item) begin
			op_q       <= s_tdata[1:0];
			item_row_q <= s_tdata[7:2];
			item_col_q <= s_tdata[13:8];
			item_cin_q <= s_tdata[14];
		end
	end

	assign row_ext   = DW'(item_row_q);
	assign col_ext   = DW'(item_col_q);
	assign oor_w     = (row_ext >= nr) || (col_ext >= nc);
	assign item_addr = row_ext[RW-1:0];
	assign col_sel   = col_ext[CW-1:0];

	always_comb begin
		mod_row          = rdata_q;
		mod_row[col_sel] = item_cin_q;
	end

	// counters
	assign rc_nxt   = {1'b0, rc_q} + 1'b1;
	assign row_more = DW'(rc_nxt) < nr;
	assign cc_nxt   = {1'b0, cc_q} + 1'b1;
	assign col_in   = DW'(cc_q) < nc;
	assign right_in = DW'(cc_nxt) < nc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= '0;
			cc_q <= '0;
		end else begin
			if (cmd.clr_step) begin
				rc_q <= (rc_q == RW'(MAX_ROWS - 1)) ? '0 : rc_nxt[RW-1:0];
			end else if (cmd.adv_init) begin
				rc_q <= '0;
			end else if (cmd.adv_write) begin
				rc_q <= row_more ? rc_nxt[RW-1:0] : '0;
			end
			if (cmd.adv_next) begin
				cc_q <= '0;
			end else if (cmd.adv_sweep) begin
				cc_q <= (cc_q == CW'(MAX_COLS - 1)) ? '0 : cc_nxt[CW-1:0];
			end
		end
	end

	// grid memory, one row per word
	assign re    = cmd.acc_rd || cmd.adv_init || cmd.adv_next;
	assign raddr = cmd.acc_rd ? item_addr :
	               cmd.adv_next ? (row_more ? rc_nxt[RW-1:0] : rc_q) : '0;
	assign we    = cmd.clr_step || cmd.acc_wr || cmd.adv_write;
	assign waddr = cmd.acc_wr ? item_addr : rc_q;
	assign wdata = cmd.clr_step ? '0 : (cmd.acc_wr ? mod_row : new_row_q);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	// three-row window, rotated one column per cycle during the column sweep
	always_comb begin
		count = 4'(lft_q[0]) + 4'(lft_q[1]) + 4'(lft_q[2]) + 4'(top_q[0]) + 4'(bot_q[0]);
		if (right_in) count = count + 4'(top_q[1]) + 4'(mid_q[1]) + 4'(bot_q[1]);
		if (col_in) begin
			new_bit = (count == 4'd3) || (mid_q[0] && (count == 4'd2));
		end else begin
			new_bit = mid_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.adv_prime) begin
			top_q <= '0;
			mid_q <= '0;
			bot_q <= rdata_q;
		end else if (cmd.adv_next) begin
			top_q <= mid_q;
			mid_q <= bot_q;
			lft_q <= '0;
		end else if (cmd.adv_fetch) begin
			bot_q <= row_more ? rdata_q : '0;
		end else if (cmd.adv_sweep) begin
			top_q     <= {top_q[0], top_q[MAX_COLS-1:1]};
			mid_q     <= {mid_q[0], mid_q[MAX_COLS-1:1]};
			bot_q     <= {bot_q[0], bot_q[MAX_COLS-1:1]};
			lft_q     <= {bot_q[0], mid_q[0], top_q[0]};
			new_row_q <= {new_bit, new_row_q[MAX_COLS-1:1]};
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_oor_q  <= sts.is_write || sts.is_read ? oor_w : 1'b0;
			out_cell_q <= sts.is_read && !oor_w && rdata_q[col_sel];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_oor_q, out_cell_q};

	always_comb begin
		sts            = '0;
		sts.clr_last   = (rc_q == RW'(MAX_ROWS - 1));
		sts.is_write   = (op_q == lgs_pkg::OP_WRITE);
		sts.is_read    = (op_q == lgs_pkg::OP_READ);
		sts.is_advance = (op_q == lgs_pkg::OP_ADVANCE);
		sts.oor        = oor_w;
		sts.empty      = (nr == '0) || (nc == '0);
		sts.row_last   = !row_more;
		sts.col_last   = (cc_q == CW'(MAX_COLS - 1));
		sts.out_free   = !out_valid_q || m_tready;
	end

endmodule

`default_nettype wire

[hdl/life_grid_generation_step.sv]
// bounded life grid, b3/s23 rule, edges do not wrap
// input beats on s_*: opcode write, read or advance one generation; one result
// beat on m_* for every input beat, in order
// config: cfg_we, cfg_index 0 (rows in use) or 1 (columns in use); the user writes
// only while no beat is in flight, not enforced; sizes above the maximum saturate
// write or read: a row read and, on a write only, a row write back before the result
// out-of-range access, unknown opcode or advance on an empty grid: no memory access
// advance: per row in use, a row fetch, a sweep over all MAX_COLS columns of one
// cell per cycle and a row write back, through one row-wide memory port
// a new beat is taken once the previous result sits in the output register
// reset: a clearing pass zeroes all MAX_ROWS rows of the grid, s_tready low
// a stalled receiver holds the result register; the block waits with it
`default_nettype none

module life_grid_generation_step #(
	parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = lgs_pkg::DEF_MAX_COLS
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire                       cfg_index,
	input  wire  [lgs_pkg::CFG_W-1:0] cfg_data,
	input  wire                       s_tvalid,
	output logic                      s_tready,
	input  wire  [15:0]               s_tdata,  // opcode, row_index, col_index, cell_in
	output logic                      m_tvalid,
	input  wire                       m_tready,
	output logic [7:0]                m_tdata   // cell_out, out_of_range
);

	lgs_pkg::cmd_t cmd;
	lgs_pkg::sts_t sts;

	lgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lgs_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire
